### rtl/perfect_hash_lookup_192_assert.svh
// Assertion macros used by the checker file of the hash lookup block.
`ifndef PERFECT_HASH_LOOKUP_192_ASSERT_SVH
`define PERFECT_HASH_LOOKUP_192_ASSERT_SVH

// Condition must never hold while out of reset.
`define PHL_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

// Same-cycle implication.
`define PHL_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PHL_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/phl_pkg.sv
// Types, constants and latency helpers of the perfect hash lookup block.
`default_nettype none

package phl_pkg;

  localparam int unsigned HT_ENTRIES_DEF = 4096;
  localparam int unsigned OT_ENTRIES_DEF = 1024;

  localparam int unsigned HASH_W     = 64;
  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned OFF_W      = 13;
  localparam int unsigned SLOT_IDX_W = 12;
  localparam int unsigned HT_SIZE_W  = 13;
  localparam int unsigned OT_SIZE_W  = 11;
  localparam int unsigned HT_RES_W   = 12;
  localparam int unsigned OT_RES_W   = 10;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 3;

  // Remainder bits resolved per pipeline stage of the modulo unit.
  localparam int unsigned MOD_STEP = 4;

  typedef enum logic [1:0] {
    OP_WR_OFFSET = 2'd0,
    OP_WR_SLOT   = 2'd1,
    OP_LOOKUP    = 2'd2
  } phl_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HT_SIZE     = 3'd0,
    REG_OT_SIZE     = 3'd1,
    REG_SHIFT64_HT  = 3'd2,
    REG_SHIFT128_HT = 3'd3,
    REG_SHIFT64_OT  = 3'd4,
    REG_SHIFT128_OT = 3'd5
  } phl_reg_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] write_address;
    logic [OFF_W-1:0]  offset_value;
    logic [HASH_W-1:0] hash_low;
    logic [HASH_W-1:0] hash_mid;
    logic [HASH_W-1:0] hash_high;
  } phl_in_t;

  typedef struct packed {
    logic                  found;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  add_overflow;
  } phl_out_t;

  // Item plus the carry out of the offset add, carried through the second reduction.
  typedef struct packed {
    logic    ovf;
    phl_in_t item;
  } phl_side_t;

  function automatic int unsigned mod_stages(input int unsigned iw);
    return (iw + MOD_STEP - 1) / MOD_STEP;
  endfunction

  function automatic int unsigned reduce_lat(input int unsigned mw, input int unsigned rw);
    return mod_stages(HASH_W) + 2 + mod_stages(mw + rw + 2);
  endfunction

  // Accept edge to result strobe, in cycles.
  function automatic int unsigned phl_latency(input int unsigned ht, input int unsigned ot);
    return 1 + reduce_lat($clog2(ot + 1), OT_RES_W) + 2
             + reduce_lat($clog2(ht + 1), HT_RES_W) + 2;
  endfunction

endpackage

`default_nettype wire

### rtl/phl_mod.sv
// Pipelined remainder unit: value modulo a runtime modulus, MOD_STEP bits a stage.
`default_nettype none

module phl_mod
  import phl_pkg::*;
#(
  parameter int unsigned IW = 64,
  parameter int unsigned MW = 13
) (
  input  logic          clk_i,
  input  logic [IW-1:0] a_i,
  input  logic [MW-1:0] m_i,
  output logic [MW-1:0] r_o
);

  localparam int unsigned NS = mod_stages(IW);
  localparam int unsigned PW = NS * MOD_STEP;

  logic [PW-1:0] a_pad;
  logic [MW-1:0] rem_q  [NS];
  logic [PW-1:0] bits_q [NS-1];

  assign a_pad = PW'(a_i);

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic [MW-1:0] rem_in;
    logic [MW-1:0] rem_d;
    logic [PW-1:0] src;
    logic [MW:0]   t;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign src    = a_pad;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign src    = bits_q[s-1];
    end

    // Restoring remainder: shift in one bit, subtract the modulus if it fits.
    always_comb begin
      rem_d = rem_in;
      t     = '0;
      for (int k = 0; k < MOD_STEP; k++) begin
        t = {rem_d, src[PW-1-s*MOD_STEP-k]};
        if (t >= {1'b0, m_i}) begin
          t = t - {1'b0, m_i};
        end
        rem_d = t[MW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d;
    end

    if (s < NS - 1) begin : g_bits
      always_ff @(posedge clk_i) begin
        bits_q[s] <= src;
      end
    end
  end

  assign r_o = rem_q[NS-1];

endmodule

`default_nettype wire

### rtl/phl_delay.sv
// Delay line for valid bits and the item that travels beside a datapath.
`default_nettype none

module phl_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic [N-1:0] vld_q;
  logic [W-1:0] data_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < N; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q[0] <= data_i;
    for (int i = 1; i < N; i++) begin
      data_q[i] <= data_q[i-1];
    end
  end

  assign valid_o = vld_q[N-1];
  assign data_o  = data_q[N-1];

endmodule

`default_nettype wire

### rtl/phl_reduce.sv
// 192-bit modulo reduction through 64-bit lanes and precomputed residues.
`default_nettype none

module phl_reduce
  import phl_pkg::*;
#(
  parameter int unsigned MW = 13,
  parameter int unsigned RW = 12,
  parameter int unsigned SW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [SW-1:0]     side_i,
  input  logic [HASH_W-1:0] lo_i,
  input  logic [HASH_W-1:0] mi_i,
  input  logic [HASH_W-1:0] hi_i,
  input  logic [MW-1:0]     m_i,
  input  logic [RW-1:0]     r64_i,
  input  logic [RW-1:0]     r128_i,
  output logic              valid_o,
  output logic [SW-1:0]     side_o,
  output logic [MW-1:0]     rem_o
);

  localparam int unsigned PW   = MW + RW;
  localparam int unsigned SUMW = PW + 2;
  localparam int unsigned LAT  = reduce_lat(MW, RW);

  logic [MW-1:0]   ra_lo, ra_mi, ra_hi;
  logic [PW-1:0]   prod_hi_q, prod_mi_q;
  logic [MW-1:0]   lo_q;
  logic [SUMW-1:0] sum_q;

  phl_mod #(.IW(HASH_W), .MW(MW)) u_mod_lo (.clk_i, .a_i(lo_i), .m_i, .r_o(ra_lo));
  phl_mod #(.IW(HASH_W), .MW(MW)) u_mod_mi (.clk_i, .a_i(mi_i), .m_i, .r_o(ra_mi));
  phl_mod #(.IW(HASH_W), .MW(MW)) u_mod_hi (.clk_i, .a_i(hi_i), .m_i, .r_o(ra_hi));

  // Weight the upper lanes by their residues, then sum.
  always_ff @(posedge clk_i) begin
    prod_hi_q <= PW'(ra_hi) * PW'(r128_i);
    prod_mi_q <= PW'(ra_mi) * PW'(r64_i);
    lo_q      <= ra_lo;
    sum_q     <= SUMW'(prod_hi_q) + SUMW'(prod_mi_q) + SUMW'(lo_q);
  end

  phl_mod #(.IW(SUMW), .MW(MW)) u_mod_sum (.clk_i, .a_i(sum_q), .m_i, .r_o(rem_o));

  phl_delay #(.W(SW), .N(LAT)) u_side (
    .clk_i,
    .rst_ni,
    .valid_i,
    .data_i  (side_i),
    .valid_o,
    .data_o  (side_o)
  );

endmodule

`default_nettype wire

### rtl/perfect_hash_lookup_192.sv
// Top level of the two-level perfect hash lookup for 192-bit digests.
//
// Items enter on item_i when start_i is high and busy_o is low; one item may
// enter every cycle. Offset writes and slot writes produce no result. A lookup
// produces one result on result_o, marked by done_o for exactly one cycle;
// phl_latency gives its delay from the accepting edge. Results leave in item
// order. The latency is set by the two pipelined 192-bit reductions, each
// 64-bit lane resolving four remainder bits a stage. Writes take effect at
// the stage where lookups read the same table, so every item sees all earlier
// writes. Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_data_i; the user must write them only while no item is in flight, which
// the block does not enforce. After reset busy_o stays high while the slot
// table is cleared to zero; configuration writes are taken during that time.
// The receiver cannot stall: a result is present for its one cycle only.
`default_nettype none

module perfect_hash_lookup_192
  import phl_pkg::*;
#(
  parameter int unsigned HT_ENTRIES = HT_ENTRIES_DEF,
  parameter int unsigned OT_ENTRIES = OT_ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  phl_in_t               item_i,
  output logic                  done_o,
  output phl_out_t              result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned HT_AW   = $clog2(HT_ENTRIES);
  localparam int unsigned OT_AW   = $clog2(OT_ENTRIES);
  localparam int unsigned HT_MW   = $clog2(HT_ENTRIES + 1);
  localparam int unsigned OT_MW   = $clog2(OT_ENTRIES + 1);
  localparam int unsigned HT_XW   = (HT_AW > ADDR_W) ? HT_AW : ADDR_W;
  localparam int unsigned OT_XW   = (OT_AW > ADDR_W) ? OT_AW : ADDR_W;
  localparam int unsigned SIDE1_W = $bits(phl_in_t);
  localparam int unsigned SIDE2_W = $bits(phl_side_t);
  localparam int unsigned SUM_W   = 3 * HASH_W;

  // Configuration registers
  logic [HT_SIZE_W-1:0] ht_size_q;
  logic [OT_SIZE_W-1:0] ot_size_q;
  logic [HT_RES_W-1:0]  shift64_ht_q, shift128_ht_q;
  logic [OT_RES_W-1:0]  shift64_ot_q, shift128_ot_q;
  logic [HT_MW-1:0]     ht_eff;
  logic [OT_MW-1:0]     ot_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ht_size_q     <= HT_SIZE_W'(4096);
      ot_size_q     <= OT_SIZE_W'(1024);
      shift64_ht_q  <= '0;
      shift128_ht_q <= '0;
      shift64_ot_q  <= '0;
      shift128_ot_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HT_SIZE:     ht_size_q     <= cfg_data_i[HT_SIZE_W-1:0];
        REG_OT_SIZE:     ot_size_q     <= cfg_data_i[OT_SIZE_W-1:0];
        REG_SHIFT64_HT:  shift64_ht_q  <= cfg_data_i[HT_RES_W-1:0];
        REG_SHIFT128_HT: shift128_ht_q <= cfg_data_i[HT_RES_W-1:0];
        REG_SHIFT64_OT:  shift64_ot_q  <= cfg_data_i[OT_RES_W-1:0];
        REG_SHIFT128_OT: shift128_ot_q <= cfg_data_i[OT_RES_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero or oversized moduli fall back to the full table.
  assign ht_eff = (ht_size_q == '0 || 32'(ht_size_q) > HT_ENTRIES) ?
                  HT_MW'(HT_ENTRIES) : HT_MW'(ht_size_q);
  assign ot_eff = (ot_size_q == '0 || 32'(ot_size_q) > OT_ENTRIES) ?
                  OT_MW'(OT_ENTRIES) : OT_MW'(ot_size_q);

  // Slot table clearing after reset
  logic             clr_q;
  logic [HT_AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == HT_AW'(HT_ENTRIES - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  assign busy_o = clr_q;

  // Input register
  logic    in_vld_q;
  phl_in_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= item_i;
  end

  // First reduction: offset table index
  logic               r1_vld;
  logic [SIDE1_W-1:0] r1_side;
  phl_in_t            r1_item;
  logic [OT_MW-1:0]   r1_rem;

  phl_reduce #(.MW(OT_MW), .RW(OT_RES_W), .SW(SIDE1_W)) u_reduce_ot (
    .clk_i,
    .rst_ni,
    .valid_i (in_vld_q),
    .side_i  (SIDE1_W'(in_q)),
    .lo_i    (in_q.hash_low),
    .mi_i    (in_q.hash_mid),
    .hi_i    (in_q.hash_high),
    .m_i     (ot_eff),
    .r64_i   (shift64_ot_q),
    .r128_i  (shift128_ot_q),
    .valid_o (r1_vld),
    .side_o  (r1_side),
    .rem_o   (r1_rem)
  );

  assign r1_item = phl_in_t'(r1_side);

  // Offset table: write and read at the same stage to keep item order
  logic [OFF_W-1:0] offset_mem [OT_ENTRIES];
  logic [OFF_W-1:0] off_rd_q;
  logic [OT_XW-1:0] ot_wa_ext;
  logic             ot_we;
  logic             o_vld_q;
  phl_in_t          o_item_q;

  assign ot_wa_ext = OT_XW'(r1_item.write_address);
  assign ot_we     = r1_vld && (r1_item.operation == OP_WR_OFFSET) &&
                     (32'(r1_item.write_address) < OT_ENTRIES);

  always_ff @(posedge clk_i) begin
    if (ot_we) begin
      offset_mem[ot_wa_ext[OT_AW-1:0]] <= r1_item.offset_value;
    end
    off_rd_q <= offset_mem[r1_rem[OT_AW-1:0]];
    o_item_q <= r1_item;
  end

  // Add the offset to the hash
  logic           a_vld_q;
  phl_in_t        a_item_q;
  logic [SUM_W:0] a_sum;
  logic [SUM_W-1:0] a_sum_q;
  logic           a_ovf_q;
  phl_side_t      a_side;

  assign a_sum = {1'b0, o_item_q.hash_high, o_item_q.hash_mid, o_item_q.hash_low}
               + (SUM_W + 1)'(off_rd_q);

  always_ff @(posedge clk_i) begin
    a_item_q <= o_item_q;
    a_sum_q  <= a_sum[SUM_W-1:0];
    a_ovf_q  <= a_sum[SUM_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
      a_vld_q <= 1'b0;
    end else begin
      o_vld_q <= r1_vld;
      a_vld_q <= o_vld_q;
    end
  end

  assign a_side.ovf  = a_ovf_q;
  assign a_side.item = a_item_q;

  // Second reduction: hash table slot
  logic               r2_vld;
  logic [SIDE2_W-1:0] r2_side_raw;
  phl_side_t          r2_side;
  logic [HT_MW-1:0]   r2_rem;

  phl_reduce #(.MW(HT_MW), .RW(HT_RES_W), .SW(SIDE2_W)) u_reduce_ht (
    .clk_i,
    .rst_ni,
    .valid_i (a_vld_q),
    .side_i  (SIDE2_W'(a_side)),
    .lo_i    (a_sum_q[HASH_W-1:0]),
    .mi_i    (a_sum_q[2*HASH_W-1:HASH_W]),
    .hi_i    (a_sum_q[SUM_W-1:2*HASH_W]),
    .m_i     (ht_eff),
    .r64_i   (shift64_ht_q),
    .r128_i  (shift128_ht_q),
    .valid_o (r2_vld),
    .side_o  (r2_side_raw),
    .rem_o   (r2_rem)
  );

  assign r2_side = phl_side_t'(r2_side_raw);

  // Slot table: clearing pass and slot writes share one write port; lookup reads use their own address
  logic [SUM_W-1:0] slot_mem [HT_ENTRIES];
  logic [SUM_W-1:0] slot_rd_q;
  logic [HT_XW-1:0] ht_wa_ext;
  logic [HT_AW-1:0] slot_wa;
  logic [SUM_W-1:0] slot_wd;
  logic             slot_we;
  logic             m_vld_q;
  phl_side_t        m_side_q;
  logic [HT_AW-1:0] m_idx_q;

  assign ht_wa_ext = HT_XW'(r2_side.item.write_address);
  assign slot_we   = clr_q || (r2_vld && (r2_side.item.operation == OP_WR_SLOT) &&
                     (32'(r2_side.item.write_address) < HT_ENTRIES));
  assign slot_wa   = clr_q ? clr_cnt_q : ht_wa_ext[HT_AW-1:0];
  assign slot_wd   = clr_q ? '0 : {r2_side.item.hash_high, r2_side.item.hash_mid,
                                   r2_side.item.hash_low};

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd_q <= slot_mem[r2_rem[HT_AW-1:0]];
    m_side_q  <= r2_side;
    m_idx_q   <= r2_rem[HT_AW-1:0];
  end

  // Compare and drive the result
  logic             done_q;
  phl_out_t         result_q;
  logic [SUM_W-1:0] m_hash;

  assign m_hash = {m_side_q.item.hash_high, m_side_q.item.hash_mid,
                   m_side_q.item.hash_low};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      m_vld_q <= r2_vld;
      done_q  <= m_vld_q && (m_side_q.item.operation == OP_LOOKUP);
    end
  end

  always_ff @(posedge clk_i) begin
    result_q.found        <= (m_hash != '0) && (slot_rd_q == m_hash);
    result_q.slot_index   <= SLOT_IDX_W'(m_idx_q);
    result_q.add_overflow <= m_side_q.ovf;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

### rtl/phl_check.sv
// Port-level checks of the perfect hash lookup, bound to the top level.
`default_nettype none

`include "perfect_hash_lookup_192_assert.svh"

module phl_check
  import phl_pkg::*;
#(
  parameter int unsigned HT_ENTRIES = HT_ENTRIES_DEF,
  parameter int unsigned OT_ENTRIES = OT_ENTRIES_DEF
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input logic     busy_o,
  input phl_in_t  item_i,
  input logic     done_o,
  input phl_out_t result_o
);

  localparam int unsigned LAT = phl_latency(HT_ENTRIES, OT_ENTRIES);

  logic lookup_acc;
  assign lookup_acc = start_i && !busy_o && (item_i.operation == OP_LOOKUP);

  // No item can be in flight while the slot table is being cleared.
  `PHL_NEVER(a_no_done_while_busy, done_o && busy_o, "result during clearing pass")

  // Once clearing ends, busy stays low until the next reset.
  `PHL_NEXT(a_busy_stays_low, !busy_o, !busy_o, "busy rose after clearing")

  // Every result comes from a lookup accepted exactly one latency earlier.
  `PHL_IMPLY(a_done_from_lookup, done_o, $past(lookup_acc, LAT), "result without lookup")

  // The found flag is never unknown while a result is presented.
  `PHL_IMPLY(a_found_known, done_o, !$isunknown(result_o.found), "found unknown")

endmodule

bind perfect_hash_lookup_192 phl_check #(
  .HT_ENTRIES(HT_ENTRIES),
  .OT_ENTRIES(OT_ENTRIES)
) u_phl_check (.*);

`default_nettype wire
